@@ src/srft_pkg.sv @@
package srft_pkg;

    localparam int MAX_REGIONS = 16;
    localparam int IDX_W       = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
    localparam int SPACE_W     = 16;
    localparam int ADDR_W      = 64;
    localparam int PAGE_SHIFT  = 12;

    typedef enum logic [1:0] {
        MODE_REGISTER   = 2'd0,
        MODE_UNREGISTER = 2'd1,
        MODE_FAULT      = 2'd2,
        MODE_NONE       = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t               mode;
        logic [SPACE_W-1:0]  space_id;
        logic [ADDR_W-1:0]   address;
        logic [ADDR_W-1:0]   stack_size;
    } in_t;

    typedef struct packed {
        logic                grow;
        logic [ADDR_W-1:0]   page_addr;
        logic                done_res;
    } out_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic insert;
        logic step;
        logic hit;
        logic remove;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        mode_t mode;
        logic  empty;
        logic  match;
        logic  idx_zero;
    } status_t;

endpackage

@@ src/stack_region_fault_table.sv @@
// table of growable stack regions (space id, top, limit = top - max size mod 2^64),
// newest last; an item is taken when start is high and busy is low, and its one
// result beat appears on result for exactly one cycle with strobe high, which the
// receiver cannot hold off; busy stays high from acceptance through the strobe
// cycle. a register beat inserts its entry and then replies; an unregister or a fault
// lookup walks the stored regions newest first, one entry a cycle through a single
// compare unit, then replies, with a removal step before the reply when an unregister
// hits. a full table drops a register beat with done_res low.
module stack_region_fault_table (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  srft_pkg::in_t   item,
    output logic            busy,
    output logic            strobe,
    output srft_pkg::out_t  result
);
    import srft_pkg::*;

    // command and status between sequencer and table datapath
    cmd_t    cmd;
    status_t status;

    // sequencer: decodes the mode, walks the scan, times the reply beat
    srft_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .in_mode (item.mode),
        .status  (status),
        .cmd     (cmd),
        .busy    (busy),
        .strobe  (strobe)
    );

    // datapath: item capture, region table, range compare and result registers
    srft_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .status (status),
        .result (result)
    );

endmodule

@@ src/srft_dp.sv @@
module srft_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  srft_pkg::in_t     item,
    input  srft_pkg::cmd_t    cmd,
    output srft_pkg::status_t status,
    output srft_pkg::out_t    result
);
    import srft_pkg::*;

    // region table, valid entries packed in slots 0..count-1, newest last
    logic [SPACE_W-1:0] ent_space_reg [MAX_REGIONS];
    logic [ADDR_W-1:0]  ent_top_reg   [MAX_REGIONS];
    logic [ADDR_W-1:0]  ent_limit_reg [MAX_REGIONS];

    mode_t              mode_reg;
    logic [SPACE_W-1:0] space_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [ADDR_W-1:0]  size_reg;

    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               grow_reg, grow_next;
    logic               done_reg, done_next;

    logic [ADDR_W-1:0]  page;
    logic [SPACE_W-1:0] sel_space;
    logic [ADDR_W-1:0]  sel_top;
    logic [ADDR_W-1:0]  sel_limit;
    logic               full;
    logic               in_range;

    assign page      = {addr_reg[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
    assign full      = (count_reg == CNT_W'(MAX_REGIONS));
    assign sel_space = ent_space_reg[idx_reg];
    assign sel_top   = ent_top_reg[idx_reg];
    assign sel_limit = ent_limit_reg[idx_reg];
    assign in_range  = (page >= sel_limit) && (page < sel_top);

    assign status.mode     = mode_reg;
    assign status.empty    = (count_reg == '0);
    assign status.idx_zero = (idx_reg == '0);
    assign status.match    = (sel_space == space_reg)
                             && ((mode_reg == MODE_UNREGISTER) || in_range);

    assign result.grow      = grow_reg;
    assign result.page_addr = (mode_reg == MODE_FAULT) ? page : '0;
    assign result.done_res  = done_reg;

    always_comb
    begin
        count_next = count_reg;
        idx_next   = idx_reg;
        grow_next  = grow_reg;
        done_next  = done_reg;
        if (cmd.load)
        begin
            idx_next  = IDX_W'(count_reg - CNT_W'(1));
            grow_next = 1'b0;
            done_next = 1'b0;
        end
        if (cmd.step)
        begin
            idx_next = idx_reg - IDX_W'(1);
        end
        if (cmd.insert && !full)
        begin
            count_next = count_reg + CNT_W'(1);
            done_next  = 1'b1;
        end
        if (cmd.hit)
        begin
            done_next = 1'b1;
            grow_next = (mode_reg == MODE_FAULT);
        end
        if (cmd.remove)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
            grow_reg  <= 1'b0;
            done_reg  <= 1'b0;
            mode_reg  <= MODE_NONE;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
            grow_reg  <= grow_next;
            done_reg  <= done_next;
            if (cmd.load)
            begin
                mode_reg <= item.mode;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            space_reg <= item.space_id;
            addr_reg  <= item.address;
            size_reg  <= item.stack_size;
        end
    end

    // insert at the first free slot, or close the gap left by a removal
    always_ff @(posedge clk)
    begin
        if (cmd.insert && !full)
        begin
            ent_space_reg[count_reg[IDX_W-1:0]] <= space_reg;
            ent_top_reg[count_reg[IDX_W-1:0]]   <= addr_reg;
            ent_limit_reg[count_reg[IDX_W-1:0]] <= addr_reg - size_reg;
        end
        if (cmd.remove)
        begin
            for (int k = 0; k < MAX_REGIONS - 1; k++)
            begin
                if (k >= int'(idx_reg))
                begin
                    ent_space_reg[k] <= ent_space_reg[k+1];
                    ent_top_reg[k]   <= ent_top_reg[k+1];
                    ent_limit_reg[k] <= ent_limit_reg[k+1];
                end
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_REGIONS))
        else $error("region count beyond table size");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.insert && !full) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not grow the table");

    a_remove_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.remove |-> (count_reg != '0) && (idx_reg < count_reg[IDX_W-1:0]
                                             || count_reg == CNT_W'(MAX_REGIONS)))
        else $error("removal from an empty table or past the last entry");

endmodule

@@ src/srft_ctrl.sv @@
module srft_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  srft_pkg::mode_t   in_mode,
    input  srft_pkg::status_t status,
    output srft_pkg::cmd_t    cmd,
    output logic              busy,
    output logic              strobe
);
    import srft_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_INSERT = 5'b00010,
        S_SCAN   = 5'b00100,
        S_REMOVE = 5'b01000,
        S_REPLY  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    assign busy   = (state_reg != S_IDLE);
    assign strobe = (state_reg == S_REPLY);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    unique case (in_mode)
                        MODE_REGISTER:   state_next = S_INSERT;
                        MODE_UNREGISTER,
                        MODE_FAULT:      state_next = status.empty ? S_REPLY : S_SCAN;
                        MODE_NONE:       state_next = S_REPLY;
                        default:         state_next = S_REPLY;
                    endcase
                end
            end
            S_INSERT:
            begin
                cmd.insert = 1'b1;
                state_next = S_REPLY;
            end
            S_SCAN:
            begin
                priority if (status.match)
                begin
                    cmd.hit    = 1'b1;
                    state_next = (status.mode == MODE_UNREGISTER) ? S_REMOVE : S_REPLY;
                end
                else if (status.idx_zero)
                begin
                    state_next = S_REPLY;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            S_REMOVE:
            begin
                cmd.remove = 1'b1;
                state_next = S_REPLY;
            end
            S_REPLY:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    a_reply_once: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |=> !strobe && !busy)
        else $error("result strobe held longer than one cycle");

    a_remove_after_hit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.remove |-> $past(cmd.hit) && (status.mode == MODE_UNREGISTER))
        else $error("removal without a matching unregister");

endmodule
